FILE: hdl/bsdc_pkg.sv
// bsdc_pkg: shared sizes, codes and controller/datapath interface types
// for the bounded stack with duplicate check; no dependencies
package bsdc_pkg;

   localparam int DEPTH       = 64;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int CAP_W       = 7;
   localparam int POS_W       = 8;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int REQ_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_DUP       = 3'd1,
      ST_FULL      = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_BADIDX    = 3'd4,
      ST_NOTFILLED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic rd_issue;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_end;
      logic out_free;
   } sts_type;

endpackage

FILE: hdl/bsdc_ctrl.sv
// bsdc_ctrl: sequencing state machine for the stack operations
// depends on bsdc_pkg; drives commands into bsdc_dpath
module bsdc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic [bsdc_pkg::FUNC_W-1:0]  req_func,
   output logic                         req_tready,
   input  bsdc_pkg::sts_type            sts,
   output bsdc_pkg::cmd_type            cmd
);

   bsdc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsdc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bsdc_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (bsdc_pkg::func_type'(req_func))
                  bsdc_pkg::FUNC_PUSH: state_in = bsdc_pkg::S_SCAN;
                  bsdc_pkg::FUNC_POP,
                  bsdc_pkg::FUNC_READ: state_in = bsdc_pkg::S_READ;
                  default:             state_in = bsdc_pkg::S_FINISH;
               endcase
            end
         end
         bsdc_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.hit || sts.scan_end) begin
               state_in = bsdc_pkg::S_FINISH;
            end
         end
         bsdc_pkg::S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = bsdc_pkg::S_FINISH;
         end
         bsdc_pkg::S_FINISH: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = bsdc_pkg::S_IDLE;
            end
         end
         default: state_in = bsdc_pkg::S_IDLE;
      endcase
   end

endmodule

FILE: hdl/bsdc_dpath.sv
// bsdc_dpath: entry memory, fill counter, duplicate scan, capacity register
// and result register; depends on bsdc_pkg, commanded by bsdc_ctrl
module bsdc_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bsdc_pkg::CAP_W-1:0]        csr_wdata,
   input  logic [bsdc_pkg::FUNC_W-1:0]       req_func,
   input  logic [bsdc_pkg::DATA_W-1:0]       req_value,
   input  logic [bsdc_pkg::POS_W-1:0]        req_pos,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bsdc_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bsdc_pkg::DATA_W-1:0]       rsp_data,
   output logic [bsdc_pkg::CNT_W-1:0]        rsp_count,
   input  bsdc_pkg::cmd_type                 cmd,
   output bsdc_pkg::sts_type                 sts
);

   logic [bsdc_pkg::DATA_W-1:0] entries_mem [bsdc_pkg::DEPTH];

   bsdc_pkg::func_type            func_ff;
   logic [bsdc_pkg::DATA_W-1:0]   val_ff;
   logic [bsdc_pkg::POS_W-1:0]    pos_ff;
   logic [bsdc_pkg::CAP_W-1:0]    cap_ff;
   logic [bsdc_pkg::CNT_W-1:0]    filled_ff, filled_in;
   logic [bsdc_pkg::CNT_W-1:0]    scan_idx_ff;
   logic                          cmp_valid_ff;
   logic                          dup_ff;
   logic [bsdc_pkg::DATA_W-1:0]   mem_q_ff;
   logic                          rsp_valid_ff;
   bsdc_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [bsdc_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [bsdc_pkg::CNT_W-1:0]    rsp_count_ff;

   logic [bsdc_pkg::CNT_W-1:0]    eff_cap;
   logic [bsdc_pkg::ADDR_W-1:0]   rd_addr;
   logic                          mem_re;
   logic                          mem_we;
   logic                          scan_more;

   assign eff_cap = (int'(cap_ff) > bsdc_pkg::DEPTH) ?
                    bsdc_pkg::CNT_W'(bsdc_pkg::DEPTH) : bsdc_pkg::CNT_W'(cap_ff);

   assign scan_more    = (scan_idx_ff < filled_ff);
   assign sts.hit      = cmp_valid_ff && (mem_q_ff == val_ff);
   assign sts.scan_end = !scan_more && !cmp_valid_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // read address: scan pointer, top of stack for pop, position for read
   always_comb begin
      mem_re  = 1'b0;
      rd_addr = scan_idx_ff[bsdc_pkg::ADDR_W-1:0];
      if (cmd.scan_step) begin
         mem_re = scan_more;
      end else if (cmd.rd_issue) begin
         mem_re = 1'b1;
         if (func_ff == bsdc_pkg::FUNC_POP) begin
            rd_addr = bsdc_pkg::ADDR_W'(filled_ff - 1'b1);
         end else begin
            rd_addr = pos_ff[bsdc_pkg::ADDR_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_status_in = bsdc_pkg::ST_OK;
      rsp_data_in   = '0;
      filled_in     = filled_ff;
      mem_we        = 1'b0;
      unique case (func_ff)
         bsdc_pkg::FUNC_PUSH: begin
            if (dup_ff) begin
               rsp_status_in = bsdc_pkg::ST_DUP;
            end else if (filled_ff < eff_cap) begin
               mem_we    = cmd.commit;
               filled_in = filled_ff + 1'b1;
            end else begin
               rsp_status_in = bsdc_pkg::ST_FULL;
            end
         end
         bsdc_pkg::FUNC_POP: begin
            if (filled_ff != '0) begin
               rsp_data_in = mem_q_ff;
               filled_in   = filled_ff - 1'b1;
            end else begin
               rsp_status_in = bsdc_pkg::ST_EMPTY;
            end
         end
         bsdc_pkg::FUNC_READ: begin
            if (int'(pos_ff) >= int'(eff_cap)) begin
               rsp_status_in = bsdc_pkg::ST_BADIDX;
            end else if (int'(pos_ff) >= int'(filled_ff)) begin
               rsp_status_in = bsdc_pkg::ST_NOTFILLED;
            end else begin
               rsp_data_in = mem_q_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_mem[filled_ff[bsdc_pkg::ADDR_W-1:0]] <= val_ff;
      end
      if (mem_re) begin
         mem_q_ff <= entries_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= bsdc_pkg::func_type'(req_func);
         val_ff  <= req_value;
         pos_ff  <= req_pos;
      end
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= bsdc_pkg::CAP_RESET;
         filled_ff    <= '0;
         scan_idx_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (cmd.load) begin
            scan_idx_ff  <= '0;
            cmp_valid_ff <= 1'b0;
            dup_ff       <= 1'b0;
         end else if (cmd.scan_step) begin
            cmp_valid_ff <= scan_more;
            if (scan_more) begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
            if (sts.hit) begin
               dup_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            filled_ff <= filled_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

FILE: hdl/bounded_stack_with_duplicate_check_core.sv
// bounded_stack_with_duplicate_check_core: top level of the unique-entry stack
// depends on bsdc_pkg, bsdc_ctrl and bsdc_dpath
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser: func; tdata: push_value, read_position
//   rsp      out  rsp_tvalid/tready    tuser: status; tdata: read_data, fill_count
//   csr      in   csr_we               csr_wdata: capacity
//
// push: the duplicate scan reads one entry per cycle from the entry memory and
// stops at the first hit; pop and read issue one memory read, of the top entry
// or of the read position; an unused code only returns a result
// synchronous reset empties the stack and sets capacity to 64; entries hold
// no reset value. a finished beat waits in the result register while the next
// beat is taken; the result of that beat is held back until rsp is free
module bounded_stack_with_duplicate_check_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] push_value, [39:32] read_position
   input  logic [bsdc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] func
   input  logic [bsdc_pkg::FUNC_W-1:0]          req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] read_data, [38:32] fill_count, [39] zero
   output logic [bsdc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [2:0] status
   output logic [bsdc_pkg::STATUS_W-1:0]        rsp_tuser,
   input  logic                                 csr_we,
   input  logic [bsdc_pkg::CAP_W-1:0]           csr_wdata
);

   bsdc_pkg::cmd_type            cmd;
   bsdc_pkg::sts_type            sts;
   logic [bsdc_pkg::DATA_W-1:0]  rsp_data;
   logic [bsdc_pkg::CNT_W-1:0]   rsp_count;

   bsdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bsdc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_func   (req_tuser),
      .req_value  (req_tdata[bsdc_pkg::DATA_W-1:0]),
      .req_pos    (req_tdata[bsdc_pkg::DATA_W +: bsdc_pkg::POS_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .cmd        (cmd),
      .sts        (sts)
   );

   assign rsp_tdata = bsdc_pkg::RSP_TDATA_W'({rsp_count, rsp_data});

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for bounded_stack_with_duplicate_check_core
// drives req and csr, checks every rsp beat against a typed result or a prediction from its own stack copy;
// depends on bsdc_pkg and the core
module tb;

   typedef struct packed {
      bsdc_pkg::status_type          status;
      logic [bsdc_pkg::DATA_W-1:0]   data;
      logic [bsdc_pkg::CNT_W-1:0]    fill;
   } rsp_beat_type;

   typedef struct packed {
      bsdc_pkg::func_type            f;
      logic [bsdc_pkg::DATA_W-1:0]   value;
      logic [bsdc_pkg::POS_W-1:0]    pos;
      logic                          fixed;
      rsp_beat_type                  res;
   } stim_row_type;

   localparam int NUM_ROWS       = 23;
   localparam int NUM_PHASES     = 11;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = bsdc_pkg::DEPTH + 8;

   // typed results where the answer is plain; the rest go to the predictor
   localparam stim_row_type DIR_ROWS [NUM_ROWS] = '{
      '{bsdc_pkg::FUNC_POP,  32'h0000_0000, 8'd0,   1'b1,
        '{bsdc_pkg::ST_EMPTY,     32'h0000_0000, 7'd0}},
      '{bsdc_pkg::FUNC_READ, 32'h0000_0000, 8'd0,   1'b1,
        '{bsdc_pkg::ST_NOTFILLED, 32'h0000_0000, 7'd0}},
      '{bsdc_pkg::FUNC_READ, 32'h0000_0000, 8'd64,  1'b1,
        '{bsdc_pkg::ST_BADIDX,    32'h0000_0000, 7'd0}},
      '{bsdc_pkg::FUNC_READ, 32'hffff_ffff, 8'd255, 1'b1,
        '{bsdc_pkg::ST_BADIDX,    32'h0000_0000, 7'd0}},
      '{bsdc_pkg::FUNC_PUSH, 32'h8000_0000, 8'd0,   1'b1,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd1}},
      '{bsdc_pkg::FUNC_PUSH, 32'h7fff_ffff, 8'd255, 1'b1,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd2}},
      '{bsdc_pkg::FUNC_PUSH, 32'h0000_0000, 8'd0,   1'b1,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd3}},
      '{bsdc_pkg::FUNC_PUSH, 32'hffff_ffff, 8'd0,   1'b1,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd4}},
      '{bsdc_pkg::FUNC_PUSH, 32'h7fff_ffff, 8'd0,   1'b1,
        '{bsdc_pkg::ST_DUP,       32'h0000_0000, 7'd4}},
      '{bsdc_pkg::FUNC_PUSH, 32'h8000_0000, 8'd0,   1'b1,
        '{bsdc_pkg::ST_DUP,       32'h0000_0000, 7'd4}},
      '{bsdc_pkg::FUNC_READ, 32'h0000_0000, 8'd0,   1'b1,
        '{bsdc_pkg::ST_OK,        32'h8000_0000, 7'd4}},
      '{bsdc_pkg::FUNC_READ, 32'h0000_0000, 8'd3,   1'b1,
        '{bsdc_pkg::ST_OK,        32'hffff_ffff, 7'd4}},
      '{bsdc_pkg::FUNC_READ, 32'h0000_0000, 8'd4,   1'b1,
        '{bsdc_pkg::ST_NOTFILLED, 32'h0000_0000, 7'd4}},
      '{bsdc_pkg::FUNC_READ, 32'h0000_0000, 8'd63,  1'b1,
        '{bsdc_pkg::ST_NOTFILLED, 32'h0000_0000, 7'd4}},
      '{bsdc_pkg::FUNC_NOP,  32'ha5a5_a5a5, 8'h5a,  1'b1,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd4}},
      '{bsdc_pkg::FUNC_POP,  32'h0000_0000, 8'd0,   1'b1,
        '{bsdc_pkg::ST_OK,        32'hffff_ffff, 7'd3}},
      '{bsdc_pkg::FUNC_POP,  32'h0000_0000, 8'd0,   1'b1,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd2}},
      '{bsdc_pkg::FUNC_PUSH, 32'h5555_5555, 8'haa,  1'b0,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd0}},
      '{bsdc_pkg::FUNC_PUSH, 32'haaaa_aaaa, 8'h55,  1'b0,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd0}},
      '{bsdc_pkg::FUNC_READ, 32'h0000_0000, 8'd1,   1'b0,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd0}},
      '{bsdc_pkg::FUNC_READ, 32'h0000_0000, 8'd3,   1'b0,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd0}},
      '{bsdc_pkg::FUNC_PUSH, 32'h0000_0000, 8'd0,   1'b0,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd0}},
      '{bsdc_pkg::FUNC_POP,  32'h0000_0000, 8'd0,   1'b0,
        '{bsdc_pkg::ST_OK,        32'h0000_0000, 7'd0}}
   };

   localparam logic [bsdc_pkg::CAP_W-1:0] PHASE_CAP [8] = '{7'd0, 7'd1, 7'd127, 7'd64,
                                                           7'd5, 7'd100, 7'd3, 7'd64};
   localparam int PHASE_PUSH [NUM_PHASES] = '{35, 50, 90, 45, 40, 65, 45, 55, 50, 50, 50};
   localparam int PHASE_LEN  [NUM_PHASES] = '{30, 30, 120, 40, 40, 50, 30, 40, 25, 25, 25};

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bsdc_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [bsdc_pkg::FUNC_W-1:0]      req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bsdc_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [bsdc_pkg::STATUS_W-1:0]    rsp_tuser;
   logic                             csr_we     = 1'b0;
   logic [bsdc_pkg::CAP_W-1:0]       csr_wdata  = '0;

   // predictor state
   logic [bsdc_pkg::DATA_W-1:0] stack_mem [bsdc_pkg::DEPTH];
   int                          stack_fill = 0;
   logic [bsdc_pkg::CAP_W-1:0]  stack_cap  = bsdc_pkg::CAP_RESET;

   rsp_beat_type result_q [$];
   int           errors      = 0;
   int           idle_cycles = 0;
   int           stall_left  = 0;
   bit           calm        = 1'b0;

   bounded_stack_with_duplicate_check_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic rsp_beat_type apply_op(input bsdc_pkg::func_type f,
                                             input logic [bsdc_pkg::DATA_W-1:0] v,
                                             input logic [bsdc_pkg::POS_W-1:0] p);
      rsp_beat_type r;
      int           lim;
      int           i;
      bit           hit;
      lim = (stack_cap > bsdc_pkg::DEPTH) ? bsdc_pkg::DEPTH : int'(stack_cap);
      hit = 1'b0;
      r.status = bsdc_pkg::ST_OK;
      r.data = '0;
      case (f)
         bsdc_pkg::FUNC_PUSH: begin
            for (i = 0; i < stack_fill; i++)
               if (stack_mem[i] == v) hit = 1'b1;
            if (hit) begin
               r.status = bsdc_pkg::ST_DUP;
            end else if (stack_fill < lim) begin
               stack_mem[stack_fill] = v;
               stack_fill++;
            end else begin
               r.status = bsdc_pkg::ST_FULL;
            end
         end
         bsdc_pkg::FUNC_POP: begin
            if (stack_fill > 0) begin
               stack_fill--;
               r.data = stack_mem[stack_fill];
            end else begin
               r.status = bsdc_pkg::ST_EMPTY;
            end
         end
         bsdc_pkg::FUNC_READ: begin
            if (p >= lim) r.status = bsdc_pkg::ST_BADIDX;
            else if (p >= stack_fill) r.status = bsdc_pkg::ST_NOTFILLED;
            else r.data = stack_mem[p];
         end
         default: ;
      endcase
      r.fill = bsdc_pkg::CNT_W'(stack_fill);
      return r;
   endfunction

   // entered and left at a rising edge; returns once the beat is taken
   task automatic drive_req(input bsdc_pkg::func_type f,
                            input logic [bsdc_pkg::DATA_W-1:0] v,
                            input logic [bsdc_pkg::POS_W-1:0] p, input logic fixed,
                            input rsp_beat_type fixed_res);
      int           gap;
      rsp_beat_type model_res;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= bsdc_pkg::REQ_TDATA_W'({p, v});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_res = apply_op(f, v, p);
      result_q.push_back(fixed ? fixed_res : model_res);
   endtask

   initial begin : stimulus
      int                          ph, k, r, lim;
      bsdc_pkg::func_type          f;
      logic [bsdc_pkg::DATA_W-1:0] v;
      logic [bsdc_pkg::POS_W-1:0]  p;
      logic [bsdc_pkg::CAP_W-1:0]  cap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (k = 0; k < NUM_ROWS; k++)
         drive_req(DIR_ROWS[k].f, DIR_ROWS[k].value, DIR_ROWS[k].pos,
                   DIR_ROWS[k].fixed, DIR_ROWS[k].res);
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         req_tvalid <= 1'b0;
         while (result_q.size() != 0) @(posedge clock);
         cap = (ph < 8) ? PHASE_CAP[ph] : bsdc_pkg::CAP_W'($urandom_range(0, 127));
         csr_we <= 1'b1;
         csr_wdata <= cap;
         @(posedge clock);
         csr_we <= 1'b0;
         stack_cap = cap;
         calm = (ph == 3 || ph == 7);
         lim = (stack_cap > bsdc_pkg::DEPTH) ? bsdc_pkg::DEPTH : int'(stack_cap);
         for (k = 0; k < PHASE_LEN[ph]; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) f = bsdc_pkg::FUNC_NOP;
            else if (r < PHASE_PUSH[ph]) f = bsdc_pkg::FUNC_PUSH;
            else if (r < PHASE_PUSH[ph] + (100 - PHASE_PUSH[ph]) / 2) f = bsdc_pkg::FUNC_POP;
            else f = bsdc_pkg::FUNC_READ;
            r = $urandom_range(0, 99);
            if (r < 30 && stack_fill > 0) begin
               v = stack_mem[$urandom_range(0, stack_fill - 1)];
            end else if (r < 40) begin
               case ($urandom_range(0, 3))
                  0: v = 32'h8000_0000;
                  1: v = 32'h7fff_ffff;
                  2: v = '0;
                  default: v = '1;
               endcase
            end else if (r < 50) begin
               v = bsdc_pkg::DATA_W'($urandom_range(0, 15));
            end else begin
               v = $urandom;
            end
            r = $urandom_range(0, 3);
            if (r < 2) p = bsdc_pkg::POS_W'($urandom_range(0, stack_fill + 3));
            else if (r == 2) p = bsdc_pkg::POS_W'($urandom_range(0, lim + 2));
            else p = bsdc_pkg::POS_W'($urandom);
            drive_req(f, v, p, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   always @(posedge clock) begin : rsp_side
      rsp_beat_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected rsp beat, got status %0d data %h fill %0d",
                        $time, rsp_tuser, rsp_tdata[bsdc_pkg::DATA_W-1:0],
                        rsp_tdata[bsdc_pkg::DATA_W +: bsdc_pkg::CNT_W]);
               errors++;
            end else begin
               want = result_q.pop_front();
               if (rsp_tuser != want.status ||
                   rsp_tdata[bsdc_pkg::DATA_W-1:0] != want.data ||
                   rsp_tdata[bsdc_pkg::DATA_W +: bsdc_pkg::CNT_W] != want.fill) begin
                  $display("%0t: expected st %0d data %h fill %0d, got st %0d data %h fill %0d",
                           $time, want.status, want.data, want.fill, rsp_tuser,
                           rsp_tdata[bsdc_pkg::DATA_W-1:0],
                           rsp_tdata[bsdc_pkg::DATA_W +: bsdc_pkg::CNT_W]);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left <= pick_gap();
         end
      end
   end

   // no beat on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

FILE: sim.f
hdl/bsdc_pkg.sv
hdl/bsdc_ctrl.sv
hdl/bsdc_dpath.sv
hdl/bounded_stack_with_duplicate_check_core.sv
tb/tb.sv
